// File: src/hsvrgb_pkg.sv
// Package for the HSV to RGB color converter.
// Holds stream widths, arithmetic constants and hue sector codes.
// No dependencies; imported by hsv_to_rgb_converter.
package hsvrgb_pkg;

  localparam int HUE_W   = 9;
  localparam int PCT_W   = 7;
  localparam int CHAN_W  = 8;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 24;

  localparam int NSTG    = 7;

  localparam int FRAC_W  = 6;
  localparam int FAC_W   = 13;
  localparam int NUM_W   = 20;
  localparam int SCL_W   = 28;
  localparam int RCP_W   = 21;
  localparam int PROD_W  = SCL_W + RCP_W;
  localparam int SHIFT   = 40;
  localparam int QUO_W   = PROD_W - SHIFT;

  localparam logic [HUE_W-1:0]  HUE_WRAP  = 9'd360;
  localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;
  localparam logic [FAC_W-1:0]  FAC_FULL  = 13'd6000;
  localparam logic [SCL_W-1:0]  LEVEL_DEN = 28'd600000;
  localparam logic [RCP_W-1:0]  DEN_RCP   = 21'd1832519;
  localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;

  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_t;

  typedef logic [2:0][FAC_W-1:0]  fac_vec_t;
  typedef logic [2:0][NUM_W-1:0]  num_vec_t;
  typedef logic [2:0][SCL_W-1:0]  scl_vec_t;
  typedef logic [2:0][QUO_W-1:0]  quo_vec_t;
  typedef logic [2:0][CHAN_W-1:0] chan_vec_t;

endpackage

// File: src/hsv_to_rgb_converter.sv
// HSV to RGB color converter, seven-stage pipeline.
// Depends on hsvrgb_pkg for widths, constants and sector codes.
//
//   channel | direction | tdata fields (low bit up)
//   in_     | slave     | hue[8:0], saturation[15:9], brightness[22:16], zero[23]
//   out_    | master    | red[7:0], green[15:8], blue[23:16]
//
// One beat can enter every cycle while the output is not stalled.
// The stage chain is: wrap and clamp, sector split, level factors,
// brightness multiply, scale by 255, reciprocal multiply, and the quotient correction.
// Reset clears the valid bits of every stage; data registers are not reset.
// A stage holds while its successor is full and stalled, and empty stages fill up.
module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // hue, saturation, brightness
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // red, green, blue
);

  logic [NSTG:1] vld_r;
  logic [NSTG:1] rdy;

  logic [HUE_W-1:0]  hue1_r;
  logic [PCT_W-1:0]  sat1_r, brt1_r;
  sector_t           sec2_r;
  logic [FRAC_W-1:0] frac2_r;
  logic [PCT_W-1:0]  sat2_r, brt2_r;
  fac_vec_t          fac3_r;
  logic [PCT_W-1:0]  brt3_r;
  num_vec_t          num4_r;
  scl_vec_t          scl5_r;
  scl_vec_t          scl6_r;
  quo_vec_t          quo6_r;
  chan_vec_t         chan7_r;

  logic [HUE_W-1:0]  hue_in, hue_wrap;
  logic [PCT_W-1:0]  sat_in, brt_in, sat_clip, brt_clip;
  sector_t           sec_nxt;
  logic [HUE_W-1:0]  base_nxt;
  logic [HUE_W-1:0]  frac_wide;
  logic [FAC_W-1:0]  s_frac, s_sixty, fac_p, fac_q, fac_t;
  fac_vec_t          fac_nxt;
  num_vec_t          num_nxt;
  scl_vec_t          scl_nxt;
  logic [2:0][PROD_W-1:0] prod;
  logic [2:0][SCL_W-1:0]  rem;
  logic [2:0][QUO_W-1:0]  quo_fix;
  chan_vec_t         chan_nxt;

  always_comb begin
    rdy[NSTG] = out_tready | ~vld_r[NSTG];
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = ~vld_r[k] | rdy[k+1];
    end
  end

  assign in_tready  = rdy[1];
  assign out_tvalid = vld_r[NSTG];
  assign out_tdata  = {chan7_r[2], chan7_r[1], chan7_r[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) begin
        vld_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 1: hue wrap and percent clamps.
  assign hue_in   = in_tdata[HUE_W-1:0];
  assign sat_in   = in_tdata[HUE_W +: PCT_W];
  assign brt_in   = in_tdata[HUE_W+PCT_W +: PCT_W];
  assign hue_wrap = (hue_in >= HUE_WRAP) ? hue_in - HUE_WRAP : hue_in;
  assign sat_clip = (sat_in > PCT_MAX) ? PCT_MAX : sat_in;
  assign brt_clip = (brt_in > PCT_MAX) ? PCT_MAX : brt_in;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      hue1_r <= hue_wrap;
      sat1_r <= sat_clip;
      brt1_r <= brt_clip;
    end
  end

  // Stage 2: sector and fraction within the sector.
  always_comb begin
    if (hue1_r >= 9'd300) begin
      sec_nxt  = SEC_MAG_RED;
      base_nxt = 9'd300;
    end else if (hue1_r >= 9'd240) begin
      sec_nxt  = SEC_BLU_MAG;
      base_nxt = 9'd240;
    end else if (hue1_r >= 9'd180) begin
      sec_nxt  = SEC_CYN_BLU;
      base_nxt = 9'd180;
    end else if (hue1_r >= 9'd120) begin
      sec_nxt  = SEC_GRN_CYN;
      base_nxt = 9'd120;
    end else if (hue1_r >= 9'd60) begin
      sec_nxt  = SEC_YEL_GRN;
      base_nxt = 9'd60;
    end else begin
      sec_nxt  = SEC_RED_YEL;
      base_nxt = 9'd0;
    end
    frac_wide = hue1_r - base_nxt;
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      sec2_r  <= sec_nxt;
      frac2_r <= frac_wide[FRAC_W-1:0];
      sat2_r  <= sat1_r;
      brt2_r  <= brt1_r;
    end
  end

  // Stage 3: level factors over 6000 and their placement by sector.
  always_comb begin
    s_frac  = FAC_W'(sat2_r) * FAC_W'(frac2_r);
    s_sixty = FAC_W'(sat2_r) * FAC_W'(7'd60);
    fac_p   = FAC_FULL - s_sixty;
    fac_q   = FAC_FULL - s_frac;
    fac_t   = fac_p + s_frac;
    case (sec2_r)
      SEC_RED_YEL: fac_nxt = {fac_p, fac_t, FAC_FULL};
      SEC_YEL_GRN: fac_nxt = {fac_p, FAC_FULL, fac_q};
      SEC_GRN_CYN: fac_nxt = {fac_t, FAC_FULL, fac_p};
      SEC_CYN_BLU: fac_nxt = {FAC_FULL, fac_q, fac_p};
      SEC_BLU_MAG: fac_nxt = {FAC_FULL, fac_p, fac_t};
      default:     fac_nxt = {fac_q, fac_p, FAC_FULL};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      fac3_r <= fac_nxt;
      brt3_r <= brt2_r;
    end
  end

  // Stage 4: level numerators over 600000.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num_nxt[c] = NUM_W'(brt3_r) * NUM_W'(fac3_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      num4_r <= num_nxt;
    end
  end

  // Stage 5: scale by 255.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      scl_nxt[c] = {num4_r[c], 8'd0} - SCL_W'(num4_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      scl5_r <= scl_nxt;
    end
  end

  // Stage 6: quotient estimate by reciprocal, low by at most one.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = PROD_W'(scl5_r[c]) * PROD_W'(DEN_RCP);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int c = 0; c < 3; c++) begin
        quo6_r[c] <= prod[c][PROD_W-1:SHIFT];
      end
      scl6_r <= scl5_r;
    end
  end

  // Stage 7: remainder check and final clamp.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem[c]     = scl6_r[c] - SCL_W'(quo6_r[c]) * LEVEL_DEN;
      quo_fix[c] = (rem[c] >= LEVEL_DEN) ? quo6_r[c] + QUO_W'(1) : quo6_r[c];
      chan_nxt[c] = (quo_fix[c] > QUO_W'(CHAN_MAX)) ? CHAN_MAX : quo_fix[c][CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      chan7_r <= chan_nxt;
    end
  end

endmodule
